// File: sv/c_subset_token_scanner_top_macros.svh
// ----------------------------------------------------------------------------
// Token scanner assertion macros
// Shared concurrent assertion forms for the token scanner modules.
// ----------------------------------------------------------------------------
`ifndef C_SUBSET_TOKEN_SCANNER_TOP_MACROS_SVH
`define C_SUBSET_TOKEN_SCANNER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("token scanner check failed");

// Next-cycle implication, disabled while reset is high.
`define CST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("token scanner check failed");

`endif

// File: sv/cst_pkg.sv
// ----------------------------------------------------------------------------
// Token scanner package
// Transaction types, token and scanner codes, and byte classification.
// ----------------------------------------------------------------------------
package cst_pkg;

   localparam int START_W  = 16;
   localparam int LENGTH_W = 8;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [3:0] {
      KIND_INT    = 4'd0,
      KIND_RETURN = 4'd1,
      KIND_IDENT  = 4'd2,
      KIND_NUMBER = 4'd3,
      KIND_LPAREN = 4'd4,
      KIND_RPAREN = 4'd5,
      KIND_LBRACE = 4'd6,
      KIND_RBRACE = 4'd7,
      KIND_SEMI   = 4'd8,
      KIND_ERROR  = 4'd9
   } kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_WORD   = 2'd1,
      MODE_NUMBER = 2'd2
   } mode_type;

   // Progress of an open word through "int" or "return".
   typedef enum logic [3:0] {
      KW_EMPTY  = 4'd0,
      KW_I      = 4'd1,
      KW_IN     = 4'd2,
      KW_INT    = 4'd3,
      KW_R      = 4'd4,
      KW_RE     = 4'd5,
      KW_RET    = 4'd6,
      KW_RETU   = 4'd7,
      KW_RETUR  = 4'd8,
      KW_RETURN = 4'd9,
      KW_DEAD   = 4'd15
   } kw_type;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_END  = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] ch;
   } req_type;

   typedef struct packed {
      kind_type              kind;
      logic [START_W-1:0]    start_res;
      logic [LENGTH_W-1:0]   length;
      logic [7:0]            bad_char;
      logic                  last_of_run;
   } rsp_type;

   // One queue entry holds every result of one input transaction.
   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } entry_type;

   function automatic logic cst_is_alpha(input logic [7:0] c);
      return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F});
   endfunction

   function automatic logic cst_is_digit(input logic [7:0] c);
      return (c inside {[8'h30:8'h39]});
   endfunction

   function automatic logic cst_is_space(input logic [7:0] c);
      return (c inside {8'h20, [8'h09:8'h0D]});
   endfunction

   function automatic logic cst_is_punct(input logic [7:0] c);
      return (c inside {8'h28, 8'h29, 8'h7B, 8'h7D, 8'h3B});
   endfunction

   function automatic kind_type cst_punct_kind(input logic [7:0] c);
      kind_type k;
      case (c)
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h7B:   k = KIND_LBRACE;
         8'h7D:   k = KIND_RBRACE;
         8'h3B:   k = KIND_SEMI;
         default: k = KIND_ERROR;
      endcase
      return k;
   endfunction

   function automatic kw_type cst_kw_next(input kw_type kw, input logic [7:0] c);
      kw_type n;
      case (kw)
         KW_EMPTY: n = (c == 8'h69) ? KW_I : ((c == 8'h72) ? KW_R : KW_DEAD);
         KW_I:     n = (c == 8'h6E) ? KW_IN : KW_DEAD;
         KW_IN:    n = (c == 8'h74) ? KW_INT : KW_DEAD;
         KW_R:     n = (c == 8'h65) ? KW_RE : KW_DEAD;
         KW_RE:    n = (c == 8'h74) ? KW_RET : KW_DEAD;
         KW_RET:   n = (c == 8'h75) ? KW_RETU : KW_DEAD;
         KW_RETU:  n = (c == 8'h72) ? KW_RETUR : KW_DEAD;
         KW_RETUR: n = (c == 8'h6E) ? KW_RETURN : KW_DEAD;
         default:  n = KW_DEAD;
      endcase
      return n;
   endfunction

endpackage

// File: sv/cst_front.sv
// ----------------------------------------------------------------------------
// Token scanner front end
// Classifies each byte, tracks the open token and builds at most one queue entry.
// ----------------------------------------------------------------------------
module cst_front #(
   parameter int POSITION_BITS = 16,
   parameter int LENGTH_BITS   = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  cst_pkg::req_type   req_data,
   input  logic               q_full,
   output logic               push,
   output cst_pkg::entry_type push_entry
);
   import cst_pkg::*;

   mode_type                 mode_ff, mode_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [LENGTH_BITS-1:0]   len_ff, len_in;
   kw_type                   kw_ff, kw_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                     halted_ff, halted_in;

   logic       acc, byte_step, extend, do_close, do_emit_byte;
   logic       c_alpha, c_digit, c_space, c_punct, c_unknown;
   logic [7:0] c;
   rsp_type    closed_tok, byte_tok;

   assign req_ready = !q_full;
   assign acc       = req_valid && req_ready;
   assign c         = req_data.ch;

   // Byte classification and transaction events.
   always_comb begin
      c_alpha   = cst_is_alpha(c);
      c_digit   = cst_is_digit(c);
      c_space   = cst_is_space(c);
      c_punct   = cst_is_punct(c);
      c_unknown = !(c_alpha || c_digit || c_space || c_punct);
      byte_step = acc && (req_data.op == OP_BYTE) && !halted_ff;
      extend    = ((mode_ff == MODE_WORD) && (c_alpha || c_digit)) ||
                  ((mode_ff == MODE_NUMBER) && c_digit);
      do_close  = (mode_ff != MODE_IDLE) &&
                  ((acc && (req_data.op == OP_END) && !halted_ff) ||
                   (byte_step && !extend));
      do_emit_byte = byte_step && !extend && (c_punct || c_unknown);
   end

   // Next state.
   always_comb begin
      mode_in   = mode_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      kw_in     = kw_ff;
      pos_in    = pos_ff;
      halted_in = halted_ff;
      if (acc && (req_data.op == OP_END)) begin
         mode_in   = MODE_IDLE;
         start_in  = '0;
         len_in    = '0;
         kw_in     = KW_EMPTY;
         pos_in    = '0;
         halted_in = 1'b0;
      end else if (byte_step) begin
         if (pos_ff != {POSITION_BITS{1'b1}}) begin
            pos_in = pos_ff + POSITION_BITS'(1);
         end
         if (extend) begin
            if (len_ff != {LENGTH_BITS{1'b1}}) begin
               len_in = len_ff + LENGTH_BITS'(1);
            end
            if (mode_ff == MODE_WORD) begin
               kw_in = cst_kw_next(kw_ff, c);
            end
         end else begin
            mode_in  = MODE_IDLE;
            start_in = '0;
            len_in   = '0;
            kw_in    = KW_EMPTY;
            if (c_alpha) begin
               mode_in  = MODE_WORD;
               start_in = pos_ff;
               len_in   = {{(LENGTH_BITS-1){1'b0}}, 1'b1};
               kw_in    = cst_kw_next(KW_EMPTY, c);
            end else if (c_digit) begin
               mode_in  = MODE_NUMBER;
               start_in = pos_ff;
               len_in   = {{(LENGTH_BITS-1){1'b0}}, 1'b1};
            end else if (c_unknown) begin
               halted_in = 1'b1;
            end
         end
      end
   end

   // Outputs: the token being closed and the token made by this byte.
   always_comb begin
      if (mode_ff == MODE_NUMBER) begin
         closed_tok.kind = KIND_NUMBER;
      end else if (kw_ff == KW_INT) begin
         closed_tok.kind = KIND_INT;
      end else if (kw_ff == KW_RETURN) begin
         closed_tok.kind = KIND_RETURN;
      end else begin
         closed_tok.kind = KIND_IDENT;
      end
      closed_tok.start_res   = START_W'(start_ff);
      closed_tok.length      = LENGTH_W'(len_ff);
      closed_tok.bad_char    = 8'h00;
      closed_tok.last_of_run = !do_emit_byte;

      byte_tok.kind        = c_unknown ? KIND_ERROR : cst_punct_kind(c);
      byte_tok.start_res   = START_W'(pos_ff);
      byte_tok.length      = {{(LENGTH_W-1){1'b0}}, 1'b1};
      byte_tok.bad_char    = c_unknown ? c : 8'h00;
      byte_tok.last_of_run = 1'b1;

      push              = do_close || do_emit_byte;
      push_entry.two    = do_close && do_emit_byte;
      push_entry.first  = do_close ? closed_tok : byte_tok;
      push_entry.second = byte_tok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         start_ff  <= '0;
         len_ff    <= '0;
         kw_ff     <= KW_EMPTY;
         pos_ff    <= '0;
         halted_ff <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
         kw_ff     <= kw_in;
         pos_ff    <= pos_in;
         halted_ff <= halted_in;
      end
   end

endmodule

// File: sv/cst_queue.sv
// ----------------------------------------------------------------------------
// Token scanner entry queue
// Small FIFO of result entries between the front end and the output stage.
// ----------------------------------------------------------------------------
`include "c_subset_token_scanner_top_macros.svh"

module cst_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cst_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output cst_pkg::entry_type head_entry
);
   import cst_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `CST_ASSERT_NOW(a_no_push_full, clock, reset, push, !full)
   `CST_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, head_valid)
   `CST_ASSERT_NOW(a_empty_ptrs, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff)

endmodule

// File: sv/cst_back.sv
// ----------------------------------------------------------------------------
// Token scanner output stage
// Unpacks queue entries into one result transaction per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
`include "c_subset_token_scanner_top_macros.svh"

module cst_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  cst_pkg::entry_type head_entry,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output cst_pkg::rsp_type   rsp_data
);
   import cst_pkg::*;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    pend_valid_ff, pend_valid_in;
   rsp_type pend_ff, pend_in;
   logic    advance;

   assign advance   = !out_valid_ff || rsp_ready;
   assign pop       = advance && !pend_valid_ff && head_valid;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (advance) begin
         if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = pend_ff;
            pend_valid_in = 1'b0;
         end else if (head_valid) begin
            out_valid_in  = 1'b1;
            out_in        = head_entry.first;
            pend_valid_in = head_entry.two;
            pend_in       = head_entry.second;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   `CST_ASSERT_NOW(a_pend_behind_out, clock, reset, pend_valid_ff, out_valid_ff)
   `CST_ASSERT_NOW(a_pend_first_not_last, clock, reset, pend_valid_ff,
                   !out_ff.last_of_run && pend_ff.last_of_run)
   `CST_ASSERT_NEXT(a_second_follows, clock, reset,
                    rsp_valid && rsp_ready && !rsp_data.last_of_run, rsp_valid)

endmodule

// File: sv/c_subset_token_scanner_top.sv
// The first result passes from the queue into the output register, and the
// second result of a two-result transaction follows from the pending register.
// Throughput: one input transaction per cycle while the four-entry queue has room; the
// output stage sends at most one result per cycle, which sets the long-run rate.
// Reset (synchronous, active high) returns the scanner to idle at offset zero, not halted,
// and empties the queue and output stage.
// ----------------------------------------------------------------------------
// C subset token scanner
// Streams source bytes in and emits keyword, identifier, integer, punctuation
// and error tokens as kind, start offset and length.
// ----------------------------------------------------------------------------
module c_subset_token_scanner_top #(
   parameter int POSITION_BITS = 16,
   parameter int LENGTH_BITS   = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cst_pkg::rsp_type rsp_data
);
   import cst_pkg::*;

   // The front end takes one byte transaction per cycle whenever the queue has
   // room. It keeps the open-token state (mode, start, length, keyword progress),
   // the running byte offset and the halted flag, and turns each transaction into
   // at most one queue entry holding its one or two results.
   logic      push;
   entry_type push_entry;
   logic      q_full;

   // The queue decouples scanning from the result channel, so a stalled
   // consumer does not stall the byte stream until the queue fills.
   logic      head_valid;
   entry_type head_entry;
   logic      pop;

   cst_front #(
      .POSITION_BITS (POSITION_BITS),
      .LENGTH_BITS   (LENGTH_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   cst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // The output stage presents results from a register, with a second
   // register holding the trailing result of a two-result entry.
   cst_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
